// ----- rtl/fht_pkg.sv -----
// Shared types and defaults for the IP fragment hole tracker.
package fht_pkg;

    localparam int MAX_HOLES_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 16;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DONE = 2'd1,
        ST_OVF  = 2'd2
    } status_t;

    // Outcome of processing the head hole in one step
    typedef struct packed {
        logic emit;
        logic pop;
        logic replace;
        logic ovf;
    } step_t;

    // Per-cycle commands broadcast to every cell of the hole chain
    typedef struct packed {
        logic wr;
        logic rep;
        logic shift;
    } cell_ctl_t;

endpackage

// ----- rtl/ip_fragment_hole_tracker_unit.sv -----
// Flow: a request is registered, then the head unit processes the stored holes in turn (a hole
// that splits is processed once more), then the result is registered once the output is free;
// a clear or an ignored request skips the hole walk.
// Throughput: one request at a time; the hole chain shifts toward the head cell
// as holes are popped.
// Reset: asynchronous, active low; the table holds one open hole from offset 0.
module ip_fragment_hole_tracker_unit
    import fht_pkg::*;
#(
    parameter int MAX_HOLES   = MAX_HOLES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] first_byte,
    input  logic [15:0] last_byte,
    input  logic        final_piece,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  holes_left,
    output logic        complete
);

    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int IW = $clog2(MAX_HOLES);
    localparam int OB = OFFSET_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, r_reg, p_reg;
    logic [OB-1:0] f_reg, l_reg;
    logic          fin_reg, clr_reg, skip_reg;
    status_t       st_reg;
    logic          out_valid_reg;
    status_t       status_reg;
    logic [3:0]    holes_reg;
    logic          complete_reg;

    logic [OB-1:0] f_in, l_in;
    logic          in_acc, out_free, stepping, finishing, full;
    logic [CW:0]   sum;
    logic [IW-1:0] wr_idx;
    logic [CW-1:0] new_cnt;
    step_t         st;
    cell_ctl_t     ctl;

    logic [OB-1:0] c_lo [MAX_HOLES];
    logic [OB-1:0] c_hi [MAX_HOLES];
    logic          c_op [MAX_HOLES];
    logic [OB-1:0] e_lo, e_hi, hr_lo, hr_hi, r_lo, r_hi;
    logic          e_op, hr_op, r_op;

    assign f_in      = OB'(first_byte);
    assign l_in      = OB'(last_byte);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign stepping  = (state_reg == S_RUN) && (r_reg != '0);
    assign finishing = (state_reg == S_RUN) && (r_reg == '0) && out_free;
    assign full      = (cnt_reg == CW'(MAX_HOLES));
    assign sum       = (CW+1)'(r_reg) + (CW+1)'(p_reg);
    assign wr_idx    = st.pop ? IW'(sum - (CW+1)'(1)) : IW'(sum);
    assign new_cnt   = clr_reg ? CW'(1) : (skip_reg ? cnt_reg : p_reg);

    assign ctl.wr    = stepping && st.emit;
    assign ctl.rep   = (stepping && st.replace) || (finishing && clr_reg);
    assign ctl.shift = stepping && st.pop;

    // clear reloads the head cell with the single open hole
    assign r_lo = clr_reg ? '0 : hr_lo;
    assign r_hi = clr_reg ? '1 : hr_hi;
    assign r_op = clr_reg ? 1'b1 : hr_op;

    fht_head #(
        .OB (OB)
    ) u_head (
        .h_lo (c_lo[0]),
        .h_hi (c_hi[0]),
        .h_op (c_op[0]),
        .f    (f_reg),
        .l    (l_reg),
        .fin  (fin_reg),
        .full (full),
        .st   (st),
        .e_lo (e_lo),
        .e_hi (e_hi),
        .e_op (e_op),
        .r_lo (hr_lo),
        .r_hi (hr_hi),
        .r_op (hr_op)
    );

    for (genvar i = 0; i < MAX_HOLES; i++)
    begin : g_cell
        logic [OB-1:0] n_lo, n_hi;
        logic          n_op;
        if (i == MAX_HOLES - 1)
        begin : g_last
            assign n_lo = '0;
            assign n_hi = '0;
            assign n_op = 1'b0;
        end
        else
        begin : g_mid
            assign n_lo = c_lo[i+1];
            assign n_hi = c_hi[i+1];
            assign n_op = c_op[i+1];
        end
        fht_cell #(
            .OB  (OB),
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .wr_idx (wr_idx),
            .wr_lo  (e_lo),
            .wr_hi  (e_hi),
            .wr_op  (e_op),
            .rep_lo (r_lo),
            .rep_hi (r_hi),
            .rep_op (r_op),
            .nbr_lo (n_lo),
            .nbr_hi (n_hi),
            .nbr_op (n_op),
            .lo     (c_lo[i]),
            .hi     (c_hi[i]),
            .op     (c_op[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (finishing)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= CW'(1);
            r_reg         <= '0;
            p_reg         <= '0;
            f_reg         <= '0;
            l_reg         <= '0;
            fin_reg       <= 1'b0;
            clr_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            holes_reg     <= '0;
            complete_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_acc)
            begin
                f_reg    <= f_in;
                l_reg    <= l_in;
                fin_reg  <= final_piece;
                clr_reg  <= !req_type;
                skip_reg <= req_type && ((cnt_reg == '0) || (f_in > l_in));
                r_reg    <= (!req_type || (cnt_reg == '0) || (f_in > l_in)) ? '0 : cnt_reg;
                p_reg    <= '0;
                st_reg   <= (req_type && (cnt_reg == '0)) ? ST_DONE : ST_OK;
            end
            if (stepping)
            begin
                if (st.pop)
                begin
                    r_reg <= r_reg - CW'(1);
                end
                if (st.emit)
                begin
                    p_reg <= p_reg + CW'(1);
                end
                if (st.ovf)
                begin
                    st_reg <= ST_OVF;
                end
            end
            if (finishing)
            begin
                cnt_reg       <= new_cnt;
                out_valid_reg <= 1'b1;
                status_reg    <= st_reg;
                holes_reg     <= 4'(new_cnt);
                complete_reg  <= (new_cnt == '0);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign holes_left = holes_reg;
    assign complete   = complete_reg;

    a_room : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (sum <= (CW+1)'(MAX_HOLES)))
        else $error("hole chain over capacity");

    a_cnt : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_HOLES))
        else $error("hole count out of range");

    a_fin : assert property (@(posedge clk) disable iff (!rst_n)
        finishing |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not registered on finish");

    a_ovf : assert property (@(posedge clk) disable iff (!rst_n)
        (stepping && st.ovf) |-> full)
        else $error("overflow without a full table");

    a_done : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_DONE)) |-> complete_reg)
        else $error("complete status without completion");

endmodule

// ----- rtl/fht_cell.sv -----
// One hole descriptor cell of the chain: holds, shifts from its neighbor or loads.
module fht_cell
    import fht_pkg::*;
#(
    parameter int OB  = OFFSET_BITS_DEF,
    parameter int IW  = 3,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_ctl_t     ctl,
    input  logic [IW-1:0] wr_idx,
    input  logic [OB-1:0] wr_lo,
    input  logic [OB-1:0] wr_hi,
    input  logic          wr_op,
    input  logic [OB-1:0] rep_lo,
    input  logic [OB-1:0] rep_hi,
    input  logic          rep_op,
    input  logic [OB-1:0] nbr_lo,
    input  logic [OB-1:0] nbr_hi,
    input  logic          nbr_op,
    output logic [OB-1:0] lo,
    output logic [OB-1:0] hi,
    output logic          op
);

    logic [OB-1:0] lo_reg, lo_next;
    logic [OB-1:0] hi_reg, hi_next;
    logic          op_reg, op_next;
    logic          hit_wr;
    logic          hit_rep;

    assign hit_wr  = ctl.wr && (wr_idx == IW'(IDX));
    assign hit_rep = ctl.rep && (IDX == 0);

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        op_next = op_reg;
        if (hit_wr)
        begin
            lo_next = wr_lo;
            hi_next = wr_hi;
            op_next = wr_op;
        end
        else if (hit_rep)
        begin
            lo_next = rep_lo;
            hi_next = rep_hi;
            op_next = rep_op;
        end
        else if (ctl.shift)
        begin
            lo_next = nbr_lo;
            hi_next = nbr_hi;
            op_next = nbr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0;
            hi_reg <= '1;
            op_reg <= 1'b1;
        end
        else
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            op_reg <= op_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;
    assign op = op_reg;

endmodule

// ----- rtl/fht_head.sv -----
// Head unit: trims one hole against a fragment and yields the pieces that remain.
module fht_head
    import fht_pkg::*;
#(
    parameter int OB = OFFSET_BITS_DEF
)
(
    input  logic [OB-1:0] h_lo,
    input  logic [OB-1:0] h_hi,
    input  logic          h_op,
    input  logic [OB-1:0] f,
    input  logic [OB-1:0] l,
    input  logic          fin,
    input  logic          full,
    output step_t         st,
    output logic [OB-1:0] e_lo,
    output logic [OB-1:0] e_hi,
    output logic          e_op,
    output logic [OB-1:0] r_lo,
    output logic [OB-1:0] r_hi,
    output logic          r_op
);

    localparam logic [OB-1:0] MaxOff = '1;

    logic          drop;
    logic [OB-1:0] hi1;
    logic          op1;
    logic          ovl;
    logic          pre;
    logic          post;

    assign drop = fin && (h_lo > l);
    assign hi1  = (fin && (h_op || (h_hi > l))) ? l : h_hi;
    assign op1  = h_op && !fin;
    assign ovl  = (op1 || (f <= hi1)) && (l >= h_lo);
    assign pre  = f > h_lo;
    assign post = op1 ? (l != MaxOff) : (l < hi1);

    always_comb
    begin
        st   = '0;
        e_lo = h_lo;
        e_hi = hi1;
        e_op = op1;
        r_lo = l + OB'(1);
        r_hi = hi1;
        r_op = op1;
        if (drop)
        begin
            st.pop = 1'b1;
        end
        else if (!ovl)
        begin
            st.emit = 1'b1;
            st.pop  = 1'b1;
        end
        else if (pre)
        begin
            // piece before the fragment goes out first
            e_hi    = f - OB'(1);
            e_op    = 1'b0;
            st.emit = 1'b1;
            if (post && !full)
            begin
                st.replace = 1'b1;
            end
            else
            begin
                st.pop = 1'b1;
                st.ovf = post;
            end
        end
        else if (post)
        begin
            e_lo    = l + OB'(1);
            st.emit = 1'b1;
            st.pop  = 1'b1;
        end
        else
        begin
            st.pop = 1'b1;
        end
    end

endmodule

// ----- test/ip_fragment_hole_tracker_unit_tb.sv -----
// Self-checking testbench for the IP fragment hole tracker with a cycle-free hole table model.
`timescale 1ns / 100ps

module ip_fragment_hole_tracker_unit_tb;
    import fht_pkg::*;

    localparam int NHOLES = 8;
    localparam logic [15:0] TOP_OFF = 16'hFFFF;

    typedef struct {
        logic       kind;
        logic [15:0] fb;
        logic [15:0] lb;
        logic       fin;
    } frag_req_t;

    typedef struct {
        status_t    st;
        logic [3:0] cnt;
        logic       done;
    } tracker_res_t;

    typedef struct {
        logic [16:0] lo;
        logic [16:0] hi;
        logic        open;
    } hole_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic req_type;
    logic [15:0] first_byte;
    logic [15:0] last_byte;
    logic final_piece;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic [3:0] holes_left;
    logic complete;

    ip_fragment_hole_tracker_unit uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .first_byte(first_byte), .last_byte(last_byte),
        .final_piece(final_piece), .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .holes_left(holes_left), .complete(complete)
    );

    frag_req_t    pending_reqs[$];
    tracker_res_t expected_results[$];
    hole_t        model_holes[NHOLES];
    int           model_count;
    int           mismatches = 0;
    int           hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void reset_holes();
        for (int i = 0; i < NHOLES; i++)
            model_holes[i] = '{17'd0, 17'd0, 1'b0};
        model_holes[0] = '{17'd0, {1'b0, TOP_OFF}, 1'b1};
        model_count = 1;
    endfunction

    // Apply one request to the hole table and return the expected result.
    function automatic tracker_res_t track_holes(frag_req_t r);
        tracker_res_t res;
        hole_t tmp[NHOLES + 1];
        hole_t h;
        int n;
        int split_at;
        int drop;
        bit bef;
        bit aft;
        logic [16:0] f;
        logic [16:0] l;
        n = 0;
        split_at = -1;
        res.st = ST_OK;
        f = {1'b0, r.fb};
        l = {1'b0, r.lb};
        if (!r.kind)
        begin
            reset_holes();
        end
        else if (model_count == 0)
        begin
            res.st = ST_DONE;
        end
        else if (f <= l)
        begin
            for (int i = 0; i < model_count; i++)
            begin
                h = model_holes[i];
                if (r.fin)
                begin
                    if (h.lo > l)
                        continue;
                    if (h.open || h.hi > l)
                    begin
                        h.open = 1'b0;
                        h.hi = l;
                    end
                end
                if (!((h.open || f <= h.hi) && l >= h.lo))
                begin
                    if (n < NHOLES + 1)
                    begin
                        tmp[n] = h;
                        n++;
                    end
                    continue;
                end
                bef = f > h.lo;
                aft = h.open ? (l < {1'b0, TOP_OFF}) : (l < h.hi);
                if (bef && n < NHOLES + 1)
                begin
                    tmp[n] = '{h.lo, f - 17'd1, 1'b0};
                    n++;
                end
                if (aft && n < NHOLES + 1)
                begin
                    if (bef)
                        split_at = n;
                    tmp[n] = '{l + 17'd1, h.hi, h.open};
                    n++;
                end
            end
            if (n > NHOLES)
            begin
                drop = (split_at >= 0) ? split_at : n - 1;
                for (int i = drop; i + 1 < n; i++)
                    tmp[i] = tmp[i + 1];
                n = NHOLES;
                res.st = ST_OVF;
            end
            for (int i = 0; i < NHOLES; i++)
            begin
                if (i < n)
                    model_holes[i] = tmp[i];
                else
                    model_holes[i] = '{17'd0, 17'd0, 1'b0};
            end
            model_count = n;
        end
        res.cnt = model_count[3:0];
        res.done = (model_count == 0);
        return res;
    endfunction

    function automatic void queue_req(logic k, logic [15:0] a, logic [15:0] b, logic fn);
        frag_req_t r;
        r = '{k, a, b, fn};
        pending_reqs.push_back(r);
        expected_results.push_back(track_holes(r));
    endfunction

    // Driver: idle a random number of cycles before offering each request.
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= 1'b0;
            first_byte <= '0;
            last_byte <= '0;
            final_piece <= 1'b0;
            in_gap <= $urandom_range(0, 9);
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0 || pending_reqs.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                req_type <= pending_reqs[0].kind;
                first_byte <= pending_reqs[0].fb;
                last_byte <= pending_reqs[0].lb;
                final_piece <= pending_reqs[0].fin;
                void'(pending_reqs.pop_front());
                in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result status=%0d holes=%0d complete=%0d",
                                 status, holes_left, complete);
                end
                else
                begin
                    if (status !== expected_results[0].st
                        || holes_left !== expected_results[0].cnt
                        || complete !== expected_results[0].done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     expected_results[0].st, expected_results[0].cnt,
                                     expected_results[0].done, status, holes_left, complete);
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (hold_off > 0)
                out_ready <= 1'b0;
            else if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else if (out_ready && out_valid)
            begin
                out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Long receiver stall so the block backs up its input.
    int hold_cyc;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 0;
            hold_cyc <= 0;
        end
        else
        begin
            if (hold_cyc < 1000)
                hold_cyc <= hold_cyc + 1;
            if (hold_cyc == 200)
                hold_off <= 400;
            else if (hold_off > 0)
                hold_off <= hold_off - 1;
        end
    end

    function automatic logic [15:0] rand_off();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return TOP_OFF;
            2: return 16'($urandom_range(0, 64));
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Well-formed datagram after a clear: random pieces of [0, len] sent out of order, with stray requests.
    function automatic void queue_datagram();
        int len;
        int cuts;
        int pos;
        int bnd[$];
        len = ($urandom_range(0, 7) == 0) ? TOP_OFF : $urandom_range(1, 4000);
        cuts = $urandom_range(1, 12);
        queue_req(1'b0, 16'($urandom), 16'($urandom), 1'($urandom));
        pos = 0;
        for (int i = 0; i < cuts && pos < len; i++)
        begin
            int nxt;
            nxt = (i == cuts - 1) ? len + 1 : $urandom_range(pos + 1, len + 1);
            bnd.push_back(pos);
            bnd.push_back(nxt - 1);
            pos = nxt;
        end
        if (pos <= len)
        begin
            bnd.push_back(pos);
            bnd.push_back(len);
        end
        while (bnd.size() > 0)
        begin
            int k;
            logic [15:0] a;
            logic [15:0] b;
            k = 2 * $urandom_range(0, bnd.size() / 2 - 1);
            a = 16'(bnd[k]);
            b = 16'(bnd[k + 1]);
            bnd.delete(k + 1);
            bnd.delete(k);
            if ($urandom_range(0, 9) == 0)
                queue_req(1'b1, rand_off(), rand_off(), 1'($urandom));
            queue_req(1'b1, a, b, b == len);
        end
        if ($urandom_range(0, 2) == 0)
            queue_req(1'b1, rand_off(), rand_off(), 1'($urandom));
    endfunction

    int guard;
    initial
    begin
        rst_n = 1'b0;
        reset_holes();
        // Directed: extremes, inverted range, top offset, overflow, after completion.
        queue_req(1'b1, 16'd5, 16'd4, 1'b1);
        queue_req(1'b1, 16'd100, TOP_OFF, 1'b0);
        queue_req(1'b1, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < 9; i++)
            queue_req(1'b1, 16'd2 + 16'(4 * i), 16'd3 + 16'(4 * i), 1'b0);
        queue_req(1'b1, 16'd0, 16'd200, 1'b1);
        queue_req(1'b1, 16'd1, 16'd1, 1'b0);
        queue_req(1'b0, TOP_OFF, TOP_OFF, 1'b1);
        queue_req(1'b1, 16'd300, 16'd400, 1'b1);
        queue_req(1'b1, 16'd500, 16'd600, 1'b1);
        queue_req(1'b1, 16'd0, TOP_OFF, 1'b1);
        queue_req(1'b1, 16'd0, 16'd0, 1'b0);
        queue_req(1'b0, 16'd0, 16'd0, 1'b0);
        queue_req(1'b1, 16'd0, TOP_OFF, 1'b0);
        queue_req(1'b1, TOP_OFF, 16'd0, 1'b1);
        queue_req(1'b0, 16'd0, 16'd0, 1'b0);
        while (expected_results.size() < 1950)
        begin
            if ($urandom_range(0, 4) == 0)
                queue_req($urandom_range(0, 15) != 0, rand_off(), rand_off(), 1'($urandom));
            else
                queue_datagram();
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        guard = 0;
        while (expected_results.size() > 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (30) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
